// File: src/iat_pkg.sv
// Shared types, codes and field widths for the indexed array table.
package iat_pkg;

   localparam int CAPACITY_DEF = 16;

   localparam int ACTION_W = 3;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int IDX_W    = 5;
   localparam int COUNT_W  = 5;

   localparam logic [IDX_W-1:0] NO_INDEX = '1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_APPEND = 3'd0,
      ACT_POP    = 3'd1,
      ACT_INSERT = 3'd2,
      ACT_ERASE  = 3'd3,
      ACT_FIND   = 3'd4,
      ACT_DUMP   = 3'd5
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE = 2'd0,
      STAT_FULL = 2'd1,
      STAT_BAD  = 2'd2
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic exec;
      logic scan_start;
      logic step;
      logic find_emit;
      logic dump_emit;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;
      logic count_zero;
      logic hit;
      logic at_end;
   } ctl_sts_type;

endpackage

// File: src/iat_if.sv
// Item channels of the indexed array table: request and response.
interface iat_req_if;
   logic                              valid;
   logic                              ready;
   logic [iat_pkg::ACTION_W-1:0]      action;
   logic [iat_pkg::POS_W-1:0]         position;
   logic signed [iat_pkg::VALUE_W-1:0] value;

   modport source (output valid, action, position, value, input ready);
   modport sink   (input valid, action, position, value, output ready);
endinterface

interface iat_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [iat_pkg::STATUS_W-1:0]       status;
   logic signed [iat_pkg::IDX_W-1:0]   found_index;
   logic signed [iat_pkg::VALUE_W-1:0] element;
   logic [iat_pkg::COUNT_W-1:0]        element_count;
   logic                               last;

   modport source (output valid, status, found_index, element, element_count, last,
                   input ready);
   modport sink   (input valid, status, found_index, element, element_count, last,
                   output ready);
endinterface

// File: src/iat_ctrl.sv
// Controller state machine: request intake, find scan and dump sequencing.
module iat_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [iat_pkg::ACTION_W-1:0] req_action,
   output logic                         req_ready,
   input  iat_pkg::ctl_sts_type         sts,
   output iat_pkg::ctl_cmd_type         cmd
);
   import iat_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_FIND = 3'b010,
      ST_DUMP = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE) && sts.out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == ACT_FIND && !sts.count_zero) begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_FIND;
               end else if (req_action == ACT_DUMP && !sts.count_zero) begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_DUMP;
               end else begin
                  cmd.exec = 1'b1;
               end
            end
         end
         ST_FIND: begin
            if (sts.hit || sts.at_end) begin
               if (sts.out_free) begin
                  cmd.find_emit = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_DUMP: begin
            if (sts.out_free) begin
               cmd.dump_emit = 1'b1;
               if (sts.at_end) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.step = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/iat_dpath.sv
// Datapath: element cells with parallel shift, count, scan index, response register.
module iat_dpath #(
   parameter int CAPACITY = iat_pkg::CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [iat_pkg::ACTION_W-1:0]        req_action,
   input  logic [iat_pkg::POS_W-1:0]           req_position,
   input  logic signed [iat_pkg::VALUE_W-1:0]  req_value,
   input  iat_pkg::ctl_cmd_type                cmd,
   output iat_pkg::ctl_sts_type                sts,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [iat_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [iat_pkg::IDX_W-1:0]    rsp_found_index,
   output logic signed [iat_pkg::VALUE_W-1:0]  rsp_element,
   output logic [iat_pkg::COUNT_W-1:0]         rsp_element_count,
   output logic                                rsp_last
);
   import iat_pkg::*;

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   logic [VALUE_W-1:0] data_ff [CAPACITY];
   logic [VALUE_W-1:0] data_in [CAPACITY];
   logic [VALUE_W-1:0] lower_nb [CAPACITY];
   logic [VALUE_W-1:0] upper_nb [CAPACITY];

   logic [CW-1:0]      count_ff, count_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [VALUE_W-1:0] key_ff, key_in;

   logic                      out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0]       out_status_ff, out_status_in;
   logic [IDX_W-1:0]          out_index_ff, out_index_in;
   logic [VALUE_W-1:0]        out_elem_ff, out_elem_in;
   logic [COUNT_W-1:0]        out_count_ff, out_count_in;
   logic                      out_last_ff, out_last_in;

   logic [CMPW-1:0]    pos_ext, cnt_ext;
   logic               full, empty;
   logic [VALUE_W-1:0] rd_data;
   status_type         ex_status;
   logic [CW-1:0]      ex_count;
   logic               do_append, do_insert, do_erase;

   generate
      for (genvar g = 0; g < CAPACITY; g++) begin : g_nb
         if (g == 0) begin : g_lo0
            assign lower_nb[g] = data_ff[g];
         end else begin : g_lo
            assign lower_nb[g] = data_ff[g-1];
         end
         if (g == CAPACITY - 1) begin : g_hiN
            assign upper_nb[g] = data_ff[g];
         end else begin : g_hi
            assign upper_nb[g] = data_ff[g+1];
         end
      end
   endgenerate

   assign pos_ext = CMPW'(req_position);
   assign cnt_ext = CMPW'(count_ff);
   assign full    = (count_ff == CW'(CAPACITY));
   assign empty   = (count_ff == '0);
   assign rd_data = data_ff[idx_ff];

   assign sts.out_free   = !out_valid_ff || rsp_ready;
   assign sts.count_zero = empty;
   assign sts.hit        = (rd_data == key_ff);
   assign sts.at_end     = (CW'(idx_ff) == count_ff - CW'(1));

   // immediate actions
   always_comb begin
      ex_status = STAT_DONE;
      ex_count  = count_ff;
      do_append = 1'b0;
      do_insert = 1'b0;
      do_erase  = 1'b0;
      case (req_action)
         ACT_APPEND: begin
            if (full) begin
               ex_status = STAT_FULL;
            end else begin
               do_append = 1'b1;
               ex_count  = count_ff + CW'(1);
            end
         end
         ACT_POP: begin
            if (empty) begin
               ex_status = STAT_BAD;
            end else begin
               ex_count = count_ff - CW'(1);
            end
         end
         ACT_INSERT: begin
            if (pos_ext > cnt_ext) begin
               ex_status = STAT_BAD;
            end else if (full) begin
               ex_status = STAT_FULL;
            end else begin
               do_insert = 1'b1;
               ex_count  = count_ff + CW'(1);
            end
         end
         ACT_ERASE: begin
            if (pos_ext >= cnt_ext) begin
               ex_status = STAT_BAD;
            end else begin
               do_erase = 1'b1;
               ex_count = count_ff - CW'(1);
            end
         end
         ACT_FIND: begin
            ex_status = STAT_DONE;
         end
         default: begin
            ex_status = STAT_BAD;
         end
      endcase
   end

   // per-cell next value
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         data_in[i] = data_ff[i];
         if (cmd.exec) begin
            if (do_append && CMPW'(i) == cnt_ext) begin
               data_in[i] = req_value;
            end else if (do_insert && CMPW'(i) == pos_ext) begin
               data_in[i] = req_value;
            end else if (do_insert && CMPW'(i) > pos_ext && CMPW'(i) <= cnt_ext) begin
               data_in[i] = lower_nb[i];
            end else if (do_erase && CMPW'(i) >= pos_ext && CMPW'(i) + CMPW'(1) < cnt_ext) begin
               data_in[i] = upper_nb[i];
            end
         end
      end
   end

   always_comb begin
      count_in = cmd.exec ? ex_count : count_ff;
      key_in   = cmd.scan_start ? req_value : key_ff;
      if (cmd.scan_start) begin
         idx_in = '0;
      end else if (cmd.step) begin
         idx_in = idx_ff + IW'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_status_in = out_status_ff;
      out_index_in  = out_index_ff;
      out_elem_in   = out_elem_ff;
      out_count_in  = out_count_ff;
      out_last_in   = out_last_ff;
      if (cmd.exec) begin
         out_valid_in  = 1'b1;
         out_status_in = ex_status;
         out_index_in  = NO_INDEX;
         out_elem_in   = '0;
         out_count_in  = COUNT_W'(ex_count);
         out_last_in   = 1'b1;
      end else if (cmd.find_emit) begin
         out_valid_in  = 1'b1;
         out_status_in = STAT_DONE;
         out_index_in  = sts.hit ? IDX_W'(idx_ff) : NO_INDEX;
         out_elem_in   = '0;
         out_count_in  = COUNT_W'(count_ff);
         out_last_in   = 1'b1;
      end else if (cmd.dump_emit) begin
         out_valid_in  = 1'b1;
         out_status_in = STAT_DONE;
         out_index_in  = NO_INDEX;
         out_elem_in   = rd_data;
         out_count_in  = COUNT_W'(count_ff);
         out_last_in   = sts.at_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff       <= data_in;
      idx_ff        <= idx_in;
      key_ff        <= key_in;
      out_status_ff <= out_status_in;
      out_index_ff  <= out_index_in;
      out_elem_ff   <= out_elem_in;
      out_count_ff  <= out_count_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_found_index   = out_index_ff;
   assign rsp_element       = out_elem_ff;
   assign rsp_element_count = out_count_ff;
   assign rsp_last          = out_last_ff;

endmodule

// File: src/indexed_array_table.sv
// Indexed array table: ordered list of signed 32-bit elements, top level.
//
// Channels: req_ch carries one action per item (append, remove last, insert,
// erase, find, dump) with a position and a value; rsp_ch returns result items,
// the final one of each request flagged by last. Both use valid/ready.
// Results: append, remove, insert, erase and rejected actions give their one
// result on the cycle after acceptance; insert and erase shift all cells in
// parallel in that cycle. Find walks the cells one per cycle through the single
// read port of the cell row, up to the first match or the last cell. Dump sends
// count results, one per cycle while rsp_ch takes them, from index zero up.
// Throughput: the next request is taken once the controller is idle and the
// response register is empty or being drained: one item per cycle for the
// single-result actions while rsp_ch is ready, none while a find or dump runs.
// Reset empties the list (count zero) and the response register; cell
// contents are not cleared. When rsp_ch stalls, the response register holds
// its item and request intake or the scan pauses until it is taken.
module indexed_array_table #(
   parameter int CAPACITY = iat_pkg::CAPACITY_DEF
) (
   input  logic       clock,
   input  logic       reset,
   iat_req_if.sink    req_ch,
   iat_rsp_if.source  rsp_ch
);
   import iat_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   iat_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_action (req_ch.action),
      .req_ready  (req_ch.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   iat_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_action        (req_ch.action),
      .req_position      (req_ch.position),
      .req_value         (req_ch.value),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_status        (rsp_ch.status),
      .rsp_found_index   (rsp_ch.found_index),
      .rsp_element       (rsp_ch.element),
      .rsp_element_count (rsp_ch.element_count),
      .rsp_last          (rsp_ch.last)
   );

endmodule

// File: test/indexed_array_table_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the indexed array table: directed and random list actions.
module indexed_array_table_tb;
   import iat_pkg::*;

   localparam int CAPACITY     = CAPACITY_DEF;
   localparam int RANDOM_ITEMS = 500;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PLAN_VIEW    = 0;
   localparam int DUT_VIEW     = 1;

   localparam logic [ACTION_W-1:0] ACT_RSVD_A = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_RSVD_B = 3'd7;

   localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = ~VALUE_MIN;

   typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIX} mix_mode_type;

   typedef struct packed {
      logic [ACTION_W-1:0]        action;
      logic [POS_W-1:0]           position;
      logic signed [VALUE_W-1:0]  value;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0]        status;
      logic signed [IDX_W-1:0]    found_index;
      logic signed [VALUE_W-1:0]  element;
      logic [COUNT_W-1:0]         element_count;
      logic                       last;
   } rsp_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid    = 1'b0;
   logic [ACTION_W-1:0]       req_action   = '0;
   logic [POS_W-1:0]          req_position = '0;
   logic signed [VALUE_W-1:0] req_value    = '0;
   logic                      rsp_ready    = 1'b0;

   iat_req_if req_ch ();
   iat_rsp_if rsp_ch ();

   assign req_ch.valid    = req_valid;
   assign req_ch.action   = req_action;
   assign req_ch.position = req_position;
   assign req_ch.value    = req_value;
   assign rsp_ch.ready    = rsp_ready;

   indexed_array_table i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // two copies of the list: one steers the stimulus, one tracks the DUT
   logic signed [VALUE_W-1:0] cells [2][CAPACITY];
   int                        cell_count [2];

   req_item_type pending_requests [$];
   rsp_item_type expected_results [$];
   rsp_item_type table_replies [$];

   int mismatches  = 0;
   int idle_cycles = 0;

   function automatic void table_action(input int view, input req_item_type rq);
      rsp_item_type r;
      int           n;
      int           p;
      logic         dumped;
      table_replies.delete();
      n      = cell_count[view];
      p      = rq.position;
      dumped = 1'b0;
      r.status      = STAT_DONE;
      r.found_index = NO_INDEX;
      r.element     = '0;
      r.last        = 1'b1;
      case (rq.action)
         ACT_APPEND: begin
            if (n >= CAPACITY) begin
               r.status = STAT_FULL;
            end else begin
               cells[view][n] = rq.value;
               n++;
            end
         end
         ACT_POP: begin
            if (n == 0) r.status = STAT_BAD;
            else n--;
         end
         ACT_INSERT: begin
            if (p > n) begin
               r.status = STAT_BAD;
            end else if (n >= CAPACITY) begin
               r.status = STAT_FULL;
            end else begin
               for (int i = n; i > p; i--) cells[view][i] = cells[view][i-1];
               cells[view][p] = rq.value;
               n++;
            end
         end
         ACT_ERASE: begin
            if (p >= n) begin
               r.status = STAT_BAD;
            end else begin
               for (int i = p + 1; i < n; i++) cells[view][i-1] = cells[view][i];
               n--;
            end
         end
         ACT_FIND: begin
            // walk down so the lowest matching index wins
            for (int i = n - 1; i >= 0; i--)
               if (cells[view][i] == rq.value) r.found_index = IDX_W'(i);
         end
         ACT_DUMP: begin
            if (n == 0) begin
               r.status = STAT_BAD;
            end else begin
               dumped = 1'b1;
               for (int i = 0; i < n; i++) begin
                  r.element       = cells[view][i];
                  r.element_count = COUNT_W'(n);
                  r.last          = (i == n - 1);
                  table_replies.insert(table_replies.size(), r);
               end
            end
         end
         default: r.status = STAT_BAD;
      endcase
      cell_count[view] = n;
      if (!dumped) begin
         r.element_count = COUNT_W'(n);
         table_replies.insert(table_replies.size(), r);
      end
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2:       return '0;
         3:       return '1;
         4, 5:    return VALUE_W'($urandom_range(0, 7));
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [ACTION_W-1:0] choose_action(input mix_mode_type m);
      int t [6];
      int r;
      r = $urandom_range(0, 99);
      case (m)
         MODE_GROW:   t = '{35, 65, 70, 80, 92, 97};
         MODE_SHRINK: t = '{8, 15, 45, 75, 88, 96};
         default:     t = '{20, 38, 50, 64, 84, 96};
      endcase
      if (r < t[0]) return ACT_APPEND;
      if (r < t[1]) return ACT_INSERT;
      if (r < t[2]) return ACT_POP;
      if (r < t[3]) return ACT_ERASE;
      if (r < t[4]) return ACT_FIND;
      if (r < t[5]) return ACT_DUMP;
      return $urandom_range(0, 1) ? ACT_RSVD_A : ACT_RSVD_B;
   endfunction

   task automatic plan_request(input logic [ACTION_W-1:0] act, input int pos,
                               input logic signed [VALUE_W-1:0] val);
      req_item_type rq;
      rq.action   = act;
      rq.position = POS_W'(pos);
      rq.value    = val;
      table_action(PLAN_VIEW, rq);
      pending_requests.insert(pending_requests.size(), rq);
   endtask

   // driver: bursts of items with random gaps
   req_item_type next_request;
   int           burst_left = 1;
   int           gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ch.ready) begin
            table_action(DUT_VIEW, '{req_action, req_position, req_value});
            foreach (table_replies[i])
               expected_results.insert(expected_results.size(), table_replies[i]);
         end
         if (!req_valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               next_request = pending_requests.pop_front();
               req_action   <= next_request.action;
               req_position <= next_request.position;
               req_value    <= next_request.value;
               req_valid    <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20)
                                                           : $urandom_range(0, 3);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: own stall pattern on ready, checks each result item
   logic [15:0]  stall_pattern = '1;
   int           pattern_age   = 0;
   rsp_item_type seen_result;
   rsp_item_type want_result;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (pattern_age == 0) begin
            stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff
                                                        : (16'($urandom()) | 16'h0001);
            pattern_age   = $urandom_range(20, 80);
         end
         pattern_age--;
         stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
         rsp_ready <= stall_pattern[0];
         if (rsp_ch.valid && rsp_ready) begin
            seen_result.status        = rsp_ch.status;
            seen_result.found_index   = rsp_ch.found_index;
            seen_result.element       = rsp_ch.element;
            seen_result.element_count = rsp_ch.element_count;
            seen_result.last          = rsp_ch.last;
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result item with nothing expected: status %0d index %0d",
                           $realtime, seen_result.status, $signed(seen_result.found_index),
                           " element %0d count %0d last %0b",
                           seen_result.element, seen_result.element_count, seen_result.last);
            end else begin
               want_result = expected_results.pop_front();
               if (seen_result.status !== want_result.status
                   || seen_result.found_index !== want_result.found_index
                   || seen_result.element !== want_result.element
                   || seen_result.element_count !== want_result.element_count
                   || seen_result.last !== want_result.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch: expected status %0d index %0d",
                              $realtime, want_result.status,
                              $signed(want_result.found_index),
                              " element %0d count %0d last %0b,",
                              want_result.element, want_result.element_count,
                              want_result.last,
                              " got status %0d index %0d",
                              seen_result.status, $signed(seen_result.found_index),
                              " element %0d count %0d last %0b",
                              seen_result.element, seen_result.element_count,
                              seen_result.last);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ch.ready) || (rsp_ch.valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $realtime, IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int                        planned;
      int                        mode_left;
      int                        pos;
      int                        n;
      mix_mode_type              mode;
      logic [ACTION_W-1:0]       act;
      logic signed [VALUE_W-1:0] val;

      for (int v = 0; v < 2; v++) begin
         cell_count[v] = 0;
         for (int i = 0; i < CAPACITY; i++) cells[v][i] = '0;
      end

      // empty list corner cases
      plan_request(ACT_DUMP, 0, '0);
      plan_request(ACT_POP, 0, '0);
      plan_request(ACT_ERASE, 0, '0);
      plan_request(ACT_FIND, 0, 5);
      plan_request(ACT_INSERT, 1, 9);
      // build, duplicates, edges of the value range
      plan_request(ACT_INSERT, 0, VALUE_MAX);
      plan_request(ACT_APPEND, 0, VALUE_MIN);
      plan_request(ACT_APPEND, 0, '0);
      plan_request(ACT_APPEND, 0, '1);
      plan_request(ACT_INSERT, 2, '0);
      plan_request(ACT_INSERT, 5, 7);
      plan_request(ACT_FIND, 0, '0);
      plan_request(ACT_FIND, 0, 12345);
      plan_request(ACT_FIND, 0, VALUE_MAX);
      plan_request(ACT_ERASE, 6, '0);
      plan_request(ACT_ERASE, 31, '0);
      plan_request(ACT_ERASE, 0, '0);
      plan_request(ACT_ERASE, cell_count[PLAN_VIEW] - 1, '0);
      plan_request(ACT_POP, 0, '0);
      plan_request(ACT_DUMP, 0, '0);
      plan_request(ACT_RSVD_A, 3, 1);
      plan_request(ACT_RSVD_B, 31, '1);
      // full list
      while (cell_count[PLAN_VIEW] < CAPACITY) plan_request(ACT_APPEND, 0, pick_value());
      plan_request(ACT_APPEND, 0, 3);
      plan_request(ACT_INSERT, CAPACITY + 1, 3);
      plan_request(ACT_INSERT, 3, 3);
      plan_request(ACT_FIND, 0, cells[PLAN_VIEW][CAPACITY-1]);
      plan_request(ACT_DUMP, 0, '0);
      plan_request(ACT_ERASE, CAPACITY - 1, '0);
      plan_request(ACT_POP, 0, '0);

      planned   = 0;
      mode_left = 0;
      mode      = MODE_MIX;
      while (planned < RANDOM_ITEMS) begin
         if (mode_left == 0) begin
            mode      = mix_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(10, 40);
         end
         mode_left--;
         act = choose_action(mode);
         n   = cell_count[PLAN_VIEW];
         case (act)
            ACT_INSERT: pos = ($urandom_range(0, 9) != 0) ? $urandom_range(0, n)
                                                         : $urandom_range(0, 31);
            ACT_ERASE:  pos = (n > 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, n - 1)
                                                                  : $urandom_range(0, 31);
            default:    pos = $urandom_range(0, 31);
         endcase
         if (act == ACT_FIND && n > 0 && $urandom_range(0, 2) != 0)
            val = cells[PLAN_VIEW][$urandom_range(0, n - 1)];
         else
            val = pick_value();
         plan_request(act, pos, val);
         planned++;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_results.size() != 0) begin
         mismatches += expected_results.size();
         $display("%0d expected result items never arrived", expected_results.size());
      end
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
